### rtl/rcpd_pkg.sv
// shared types and constants of the rc pulse capture decoder
`default_nettype none
package rcpd_pkg;

  localparam int unsigned TicksPerUsDefault = 2;
  localparam int unsigned QueueDepth        = 2;
  localparam int unsigned DutyScale         = 1000;
  localparam int unsigned FreqScale         = 1000000;
  localparam int unsigned DutyNumW          = 26;

  localparam logic [15:0] TimeoutReset = 16'd100;
  localparam logic [14:0] ThrMinReset  = 15'd1000;
  localparam logic [14:0] ThrMaxReset  = 15'd2000;

  typedef enum logic [1:0] {
    CMD_EDGE  = 2'd0,
    CMD_TICK  = 2'd1,
    CMD_CLEAR = 2'd2
  } cmd_e;

  typedef enum logic [7:0] {
    CFG_TIMEOUT = 8'd0,
    CFG_THR_MIN = 8'd1,
    CFG_THR_MAX = 8'd2
  } cfg_idx_e;

  // state snapshot handed from the front to the back
  typedef struct packed {
    logic [15:0] pw_ticks;
    logic [15:0] period_ticks;
    logic        ready;
    logic        lost;
    logic [31:0] elapsed;
  } snap_t;

  typedef struct packed {
    logic [14:0] thr_min;
    logic [14:0] thr_max;
  } thr_cfg_t;

endpackage
`default_nettype wire

### rtl/rc_pulse_capture_decoder.sv
// top level: configuration registers, front, queue and back of the pwm input decoder
// a request passes the queue, the bit-serial dividers of the back (dividend DIV_W bits,
//   26 or wider) and the result register
// the back takes a new request only when idle, after its divide and its result load;
//   a two-entry queue takes requests while the back divides or a result waits
// reset: front zero, queue empty, back idle, timeout 100 ms, throttle 1000-2000 us
`default_nettype none
module rc_pulse_capture_decoder
  import rcpd_pkg::*;
#(
  parameter int unsigned TicksPerUs = TicksPerUsDefault
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         in_valid_i,
  output logic        in_stall_o,
  input  wire  [1:0]  cmd_i,
  input  wire  [15:0] capture_stamp_i,
  output logic        out_valid_o,
  input  wire         out_stall_i,
  output logic [15:0] pulse_width_us_o,
  output logic [15:0] period_us_o,
  output logic [15:0] frequency_hz_o,
  output logic [15:0] raw_duty_permille_o,
  output logic [14:0] throttle_permille_o,
  output logic        data_ready_o,
  output logic        signal_lost_o,
  output logic [31:0] elapsed_ms_o,
  input  wire         cfg_valid_i,
  output logic        cfg_ready_o,
  input  wire  [7:0]  cfg_index_i,
  input  wire  [15:0] cfg_data_i
);

  logic [15:0] timeout_q;
  thr_cfg_t    thr_cfg_q;
  logic        q_full, q_empty, q_push, q_pop;
  snap_t       q_wdata, q_rdata;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_q         <= TimeoutReset;
      thr_cfg_q.thr_min <= ThrMinReset;
      thr_cfg_q.thr_max <= ThrMaxReset;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_TIMEOUT: timeout_q         <= cfg_data_i;
        CFG_THR_MIN: thr_cfg_q.thr_min <= cfg_data_i[14:0];
        CFG_THR_MAX: thr_cfg_q.thr_max <= cfg_data_i[14:0];
        default: ;
      endcase
    end
  end

  rcpd_front u_front (
    .clk_i, .rst_ni,
    .in_valid_i, .in_stall_o, .cmd_i, .capture_stamp_i,
    .timeout_i(timeout_q),
    .q_full_i(q_full), .q_push_o(q_push), .q_data_o(q_wdata)
  );

  rcpd_fifo #(.Depth(QueueDepth)) u_fifo (
    .clk_i, .rst_ni,
    .push_i(q_push), .push_data_i(q_wdata), .full_o(q_full),
    .pop_i(q_pop), .pop_data_o(q_rdata), .empty_o(q_empty)
  );

  rcpd_back #(.TicksPerUs(TicksPerUs)) u_back (
    .clk_i, .rst_ni,
    .q_empty_i(q_empty), .q_data_i(q_rdata), .q_pop_o(q_pop),
    .thr_cfg_i(thr_cfg_q),
    .out_valid_o, .out_stall_i,
    .pulse_width_us_o, .period_us_o, .frequency_hz_o, .raw_duty_permille_o,
    .throttle_permille_o, .data_ready_o, .signal_lost_o, .elapsed_ms_o
  );

endmodule
`default_nettype wire

### rtl/rcpd_fifo.sv
// short register queue between the front and the back
`default_nettype none
module rcpd_fifo
  import rcpd_pkg::*;
#(
  parameter int unsigned Depth = QueueDepth
) (
  input  wire   clk_i,
  input  wire   rst_ni,
  input  wire   push_i,
  input  snap_t push_data_i,
  output logic  full_o,
  input  wire   pop_i,
  output snap_t pop_data_o,
  output logic  empty_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  snap_t            mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;

  assign full_o     = (cnt_q == CntW'(Depth));
  assign empty_o    = (cnt_q == '0);
  assign pop_data_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o) else $error("queue written while full");
  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !empty_o) else $error("queue read while empty");

endmodule
`default_nettype wire

### rtl/rcpd_front.sv
// front: accepts requests, applies edge, tick and clear commands, snapshots state
`default_nettype none
module rcpd_front
  import rcpd_pkg::*;
(
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         in_valid_i,
  output logic        in_stall_o,
  input  wire  [1:0]  cmd_i,
  input  wire  [15:0] capture_stamp_i,
  input  wire  [15:0] timeout_i,
  input  wire         q_full_i,
  output logic        q_push_o,
  output snap_t       q_data_o
);

  logic [15:0] rising_q, rising_d;
  logic [15:0] pw_q, pw_d;
  logic [15:0] period_q, period_d;
  logic        await_fall_q, await_fall_d;
  logic        ready_q, ready_d;
  logic [31:0] ms_q, ms_d;
  logic [31:0] last_q, last_d;
  logic        accept;
  logic [31:0] since_pulse;

  assign in_stall_o = q_full_i;
  assign accept     = in_valid_i && !q_full_i;
  assign q_push_o   = accept;

  always_comb begin
    rising_d     = rising_q;
    pw_d         = pw_q;
    period_d     = period_q;
    await_fall_d = await_fall_q;
    ready_d      = ready_q;
    ms_d         = ms_q;
    last_d       = last_q;
    if (accept) begin
      case (cmd_i)
        CMD_EDGE: begin
          if (!await_fall_q) begin
            period_d     = capture_stamp_i - rising_q;
            rising_d     = capture_stamp_i;
            await_fall_d = 1'b1;
          end else begin
            pw_d         = capture_stamp_i - rising_q;
            await_fall_d = 1'b0;
            ready_d      = 1'b1;
            last_d       = ms_q;
          end
        end
        CMD_TICK:  ms_d = ms_q + 32'd1;
        CMD_CLEAR: ready_d = 1'b0;
        default: ;
      endcase
    end
  end

  // wrapping age of the last pulse
  assign since_pulse = ms_d - last_d;

  always_comb begin
    q_data_o.pw_ticks     = pw_d;
    q_data_o.period_ticks = period_d;
    q_data_o.ready        = ready_d;
    q_data_o.lost         = (since_pulse > {16'd0, timeout_i});
    q_data_o.elapsed      = ms_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rising_q     <= '0;
      pw_q         <= '0;
      period_q     <= '0;
      await_fall_q <= 1'b0;
      ready_q      <= 1'b0;
      ms_q         <= '0;
      last_q       <= '0;
    end else begin
      rising_q     <= rising_d;
      pw_q         <= pw_d;
      period_q     <= period_d;
      await_fall_q <= await_fall_d;
      ready_q      <= ready_d;
      ms_q         <= ms_d;
      last_q       <= last_d;
    end
  end

endmodule
`default_nettype wire

### rtl/rcpd_div.sv
// one restoring divider lane, one quotient bit per step
`default_nettype none
module rcpd_div #(
  parameter int unsigned DivW = 26
) (
  input  wire             clk_i,
  input  wire             start_i,
  input  wire             step_i,
  input  wire  [DivW-1:0] dividend_i,
  input  wire  [15:0]     divisor_i,
  output logic [DivW-1:0] quotient_o
);

  logic [15:0]     rem_q, rem_d;
  logic [DivW-1:0] quo_q, quo_d;
  logic [15:0]     dvs_q;
  logic [16:0]     trial;
  logic            fits;

  // quotient bits shift in as dividend bits shift out
  assign trial = {rem_q, quo_q[DivW-1]};
  assign fits  = (trial >= {1'b0, dvs_q});

  always_comb begin
    rem_d = rem_q;
    quo_d = quo_q;
    if (start_i) begin
      rem_d = '0;
      quo_d = dividend_i;
    end else if (step_i) begin
      rem_d = fits ? 16'(trial - {1'b0, dvs_q}) : trial[15:0];
      quo_d = {quo_q[DivW-2:0], fits};
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    if (start_i) begin
      dvs_q <= divisor_i;
    end
  end

  assign quotient_o = quo_q;

endmodule
`default_nettype wire

### rtl/rcpd_back.sv
// back: serial divides, throttle clamp and the result register
`default_nettype none
module rcpd_back
  import rcpd_pkg::*;
#(
  parameter int unsigned TicksPerUs = TicksPerUsDefault
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         q_empty_i,
  input  snap_t       q_data_i,
  output logic        q_pop_o,
  input  thr_cfg_t    thr_cfg_i,
  output logic        out_valid_o,
  input  wire         out_stall_i,
  output logic [15:0] pulse_width_us_o,
  output logic [15:0] period_us_o,
  output logic [15:0] frequency_hz_o,
  output logic [15:0] raw_duty_permille_o,
  output logic [14:0] throttle_permille_o,
  output logic        data_ready_o,
  output logic        signal_lost_o,
  output logic [31:0] elapsed_ms_o
);

  localparam int unsigned FreqNum  = TicksPerUs * FreqScale;
  localparam int unsigned FreqNumW = $clog2(FreqNum + 1);
  localparam int unsigned DivW     = (FreqNumW > DutyNumW) ? FreqNumW : DutyNumW;
  localparam int unsigned CntW     = $clog2(DivW);

  // rounded-up reciprocal of the tick rate, exact for any 16-bit tick count
  localparam int unsigned RecipShift = 24;
  localparam int unsigned RecipM     = (2 ** RecipShift + TicksPerUs - 1) / TicksPerUs;
  localparam logic [39:0] RecipMul   = 40'(RecipM);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_DIV  = 3'b010,
    S_FIN  = 3'b100
  } state_e;

  state_e          state_q, state_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            start, step, last_step, load_out;
  logic            ready_q, lost_q, per_zero_q;
  logic [31:0]     elapsed_q;
  logic [15:0]     pw_ticks_q, per_ticks_q;
  logic [39:0]     pw_prod, per_prod;
  logic [DivW-1:0] freq_quo, duty_quo;
  logic [DivW-1:0] duty_num;
  logic [15:0]     pw_us, per_us;
  logic [14:0]     span;
  logic [15:0]     over_min;
  logic [14:0]     thr;
  logic            out_valid_q, out_valid_d;

  logic [15:0] pw_us_q, per_us_q, freq_q, duty_q;
  logic [14:0] thr_q;
  logic        ready_out_q, lost_out_q;
  logic [31:0] elapsed_out_q;

  assign last_step = (cnt_q == CntW'(DivW - 1));
  assign start     = (state_q == S_IDLE) && !q_empty_i;
  assign step      = (state_q == S_DIV);
  assign q_pop_o   = start;
  assign load_out  = (state_q == S_FIN) && (!out_valid_q || !out_stall_i);
  assign duty_num  = DivW'(q_data_i.pw_ticks * 26'(DutyScale));

  rcpd_div #(.DivW(DivW)) u_div_freq (
    .clk_i, .start_i(start), .step_i(step),
    .dividend_i(DivW'(FreqNum)), .divisor_i(q_data_i.period_ticks),
    .quotient_o(freq_quo)
  );

  rcpd_div #(.DivW(DivW)) u_div_duty (
    .clk_i, .start_i(start), .step_i(step),
    .dividend_i(duty_num), .divisor_i(q_data_i.period_ticks),
    .quotient_o(duty_quo)
  );

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          state_d = S_DIV;
          cnt_d   = '0;
        end
      end
      S_DIV: begin
        cnt_d = cnt_q + CntW'(1);
        if (last_step) begin
          state_d = S_FIN;
        end
      end
      S_FIN: begin
        if (load_out) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // ticks to microseconds by reciprocal multiply
  assign pw_prod  = {24'd0, pw_ticks_q} * RecipMul;
  assign per_prod = {24'd0, per_ticks_q} * RecipMul;
  assign pw_us    = pw_prod[RecipShift +: 16];
  assign per_us   = per_prod[RecipShift +: 16];

  // throttle: width above minimum, limited to the span
  assign span     = (thr_cfg_i.thr_max > thr_cfg_i.thr_min) ?
                    thr_cfg_i.thr_max - thr_cfg_i.thr_min : '0;
  assign over_min = (pw_us > {1'b0, thr_cfg_i.thr_min}) ?
                    pw_us - {1'b0, thr_cfg_i.thr_min} : '0;
  assign thr      = (over_min > {1'b0, span}) ? span : over_min[14:0];

  always_comb begin
    out_valid_d = out_valid_q;
    if (load_out) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start) begin
      ready_q     <= q_data_i.ready;
      lost_q      <= q_data_i.lost;
      elapsed_q   <= q_data_i.elapsed;
      per_zero_q  <= (q_data_i.period_ticks == '0);
      pw_ticks_q  <= q_data_i.pw_ticks;
      per_ticks_q <= q_data_i.period_ticks;
    end
    if (load_out) begin
      pw_us_q       <= pw_us;
      per_us_q      <= per_us;
      freq_q        <= per_zero_q ? '0 :
                       (|freq_quo[DivW-1:16]) ? 16'hFFFF : freq_quo[15:0];
      duty_q        <= per_zero_q ? '0 :
                       (|duty_quo[DivW-1:16]) ? 16'hFFFF : duty_quo[15:0];
      thr_q         <= thr;
      ready_out_q   <= ready_q;
      lost_out_q    <= lost_q;
      elapsed_out_q <= elapsed_q;
    end
  end

  assign out_valid_o         = out_valid_q;
  assign pulse_width_us_o    = pw_us_q;
  assign period_us_o         = per_us_q;
  assign frequency_hz_o      = freq_q;
  assign raw_duty_permille_o = duty_q;
  assign throttle_permille_o = thr_q;
  assign data_ready_o        = ready_out_q;
  assign signal_lost_o       = lost_out_q;
  assign elapsed_ms_o        = elapsed_out_q;

  a_div_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIV && last_step) |=> state_q == S_FIN)
    else $error("divide did not finish after its last step");
  a_no_pop_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop_o |-> state_q == S_IDLE) else $error("queue popped while busy");
  a_result_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_stall_i) |=> out_valid_q && $stable(thr_q))
    else $error("stalled result overwritten");

endmodule
`default_nettype wire
